### hw/rtl/slc_pkg.sv
// ============================================================================
// slc_pkg - sorted list with cursor, shared definitions
// Field widths, action and error codes, and parameter defaults.
// ============================================================================
package slc_pkg;

    localparam int ACTION_W       = 3;
    localparam int VALUE_W        = 32;
    localparam int STORED_COUNT_W = 7;
    localparam int ERROR_W        = 3;

    localparam int CAPACITY_DEFAULT      = 64;
    localparam int ELEMENT_WIDTH_DEFAULT = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_DELETE  = 3'd1,
        ACT_QUERY   = 3'd2,
        ACT_ADVANCE = 3'd3,
        ACT_RETREAT = 3'd4,
        ACT_FIRST   = 3'd5,
        ACT_LAST    = 3'd6,
        ACT_CLEAR   = 3'd7
    } action_t;

    typedef enum logic [ERROR_W-1:0] {
        ERR_OK         = 3'd0,
        ERR_SENTINEL   = 3'd1,
        ERR_NO_ADVANCE = 3'd2,
        ERR_NO_RETREAT = 3'd3,
        ERR_FULL       = 3'd4
    } err_t;

endpackage

### hw/rtl/slc_in_if.sv
// ============================================================================
// slc_in_if - request channel of the sorted list
// Carries one action and its operand per item, valid/ready handshake.
// ============================================================================
interface slc_in_if;

    logic                                valid;
    logic                                ready;
    slc_pkg::action_t                    action;
    logic signed [slc_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);

endinterface

### hw/rtl/slc_out_if.sv
// ============================================================================
// slc_out_if - result channel of the sorted list
// Carries the cursor and list status after each action, valid/ready handshake.
// ============================================================================
interface slc_out_if;

    logic                                      valid;
    logic                                      ready;
    logic signed [slc_pkg::VALUE_W-1:0]        cursor_value;
    logic                                      on_element;
    logic                                      at_end;
    logic                                      at_start;
    logic                                      is_empty;
    logic [slc_pkg::STORED_COUNT_W-1:0]        stored_count;
    slc_pkg::err_t                             error;

    modport source (
        output valid, output cursor_value, output on_element, output at_end,
        output at_start, output is_empty, output stored_count, output error,
        input ready
    );
    modport sink (
        input valid, input cursor_value, input on_element, input at_end,
        input at_start, input is_empty, input stored_count, input error,
        output ready
    );

endinterface

### hw/rtl/sorted_list_with_cursor_unit.sv
// ============================================================================
// sorted_list_with_cursor_unit - ascending list with a movable cursor
// Element store in a single-write, single-read RAM walked by a small sequencer.
// ============================================================================
// Usage:
//   req carries an action (insert, delete at cursor, query, advance, retreat,
//   go first, go last, clear) and a value used only by insert. rsp returns one
//   item per request: the element under the cursor, the cursor position flags,
//   the element count and an error code.
//   One request is worked on at a time; req.ready is high only while the
//   sequencer is idle. Insert walks the RAM from the top element down, moving
//   each larger element up one slot, one slot per cycle. Delete moves the
//   elements above the cursor down one slot. Both walks are paced by the one
//   RAM read and one RAM write per cycle.
//   The result sits in an output register; a new request is taken while it
//   waits, and the sequencer holds its finished result until rsp.ready frees
//   the register.
//   Reset empties the list and puts the cursor on the tail sentinel. RAM
//   contents are not cleared; only slots below the count are ever read.
// ============================================================================
module sorted_list_with_cursor_unit #(
    parameter int CAPACITY      = slc_pkg::CAPACITY_DEFAULT,
    parameter int ELEMENT_WIDTH = slc_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    slc_in_if.sink     req,
    slc_out_if.source  rsp
);

    localparam int EW    = ELEMENT_WIDTH;
    localparam int VW    = slc_pkg::VALUE_W;
    localparam int SCW   = slc_pkg::STORED_COUNT_W;
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_DEL,
        S_RD,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     cursor_reg, cursor_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [EW-1:0]        v_reg, v_next;
    slc_pkg::err_t        err_reg, err_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VW-1:0]        out_value_reg, out_value_next;
    logic                 out_on_reg, out_on_next;
    logic                 out_end_reg, out_end_next;
    logic                 out_start_reg, out_start_next;
    logic                 out_empty_reg, out_empty_next;
    logic [SCW-1:0]       out_count_reg, out_count_next;
    slc_pkg::err_t        out_err_reg, out_err_next;

    logic [EW-1:0]        mem [CAPACITY];
    logic [EW-1:0]        rdata_reg;
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [EW-1:0]        wr_data;

    logic [EW-1:0]        v_in;
    logic [VW-1:0]        rdata_ext;
    logic                 on_el;
    logic                 sentinel;
    logic                 full;

    // Operand and result width adaptation between the ports and the store
    if (EW <= VW) begin : g_narrow
        assign v_in = req.value[EW-1:0];
        assign rdata_ext = {{(VW - EW){rdata_reg[EW-1]}}, rdata_reg};
    end else begin : g_wide
        assign v_in = {{(EW - VW){req.value[VW-1]}}, req.value};
        assign rdata_ext = rdata_reg[VW-1:0];
    end

    assign on_el    = (cursor_reg != '0) && (cursor_reg <= count_reg);
    assign sentinel = !on_el;
    assign full     = (count_reg >= CNT_W'(CAPACITY));

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.cursor_value = out_value_reg;
    assign rsp.on_element   = out_on_reg;
    assign rsp.at_end       = out_end_reg;
    assign rsp.at_start     = out_start_reg;
    assign rsp.is_empty     = out_empty_reg;
    assign rsp.stored_count = out_count_reg;
    assign rsp.error        = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        idx_next       = idx_reg;
        v_next         = v_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_on_next    = out_on_reg;
        out_end_next   = out_end_reg;
        out_start_next = out_start_reg;
        out_empty_next = out_empty_reg;
        out_count_next = out_count_reg;
        out_err_next   = out_err_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    err_next   = slc_pkg::ERR_OK;
                    state_next = S_RD;
                    unique case (req.action)
                        slc_pkg::ACT_INSERT:
                        begin
                            v_next = v_in;
                            if (full)
                            begin
                                err_next = slc_pkg::ERR_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = v_in;
                                count_next = count_reg + 1'b1;
                                if (cursor_reg != '0)
                                    cursor_next = cursor_reg + 1'b1;
                            end
                            else
                            begin
                                // walk down from the top element
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - 1'b1);
                                idx_next   = AW'(count_reg - 1'b1);
                                state_next = S_INS;
                            end
                        end
                        slc_pkg::ACT_DELETE:
                        begin
                            if (sentinel)
                            begin
                                err_next = slc_pkg::ERR_SENTINEL;
                            end
                            else if (cursor_reg < count_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(cursor_reg);
                                idx_next   = AW'(cursor_reg);
                                state_next = S_DEL;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        slc_pkg::ACT_QUERY:
                        begin
                            if (sentinel)
                                err_next = slc_pkg::ERR_SENTINEL;
                        end
                        slc_pkg::ACT_ADVANCE:
                        begin
                            if (cursor_reg > count_reg)
                                err_next = slc_pkg::ERR_NO_ADVANCE;
                            else
                                cursor_next = cursor_reg + 1'b1;
                        end
                        slc_pkg::ACT_RETREAT:
                        begin
                            if (cursor_reg == '0)
                                err_next = slc_pkg::ERR_NO_RETREAT;
                            else
                                cursor_next = cursor_reg - 1'b1;
                        end
                        slc_pkg::ACT_FIRST:
                        begin
                            cursor_next = CNT_W'(1);
                        end
                        slc_pkg::ACT_LAST:
                        begin
                            cursor_next = count_reg;
                        end
                        slc_pkg::ACT_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = CNT_W'(1);
                        end
                        default:
                        begin
                            state_next = S_RD;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                wr_en = 1'b1;
                if ($signed(rdata_reg) > $signed(v_reg))
                begin
                    // move the larger element up one slot
                    wr_addr = idx_reg + 1'b1;
                    wr_data = rdata_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - 1'b1;
                        idx_next = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    // slot idx+1 is the insertion point
                    wr_addr    = idx_reg + 1'b1;
                    wr_data    = v_reg;
                    count_next = count_reg + 1'b1;
                    if (cursor_reg >= CNT_W'(idx_reg) + CNT_W'(2))
                        cursor_next = cursor_reg + 1'b1;
                    state_next = S_RD;
                end
            end

            S_INS_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = v_reg;
                count_next = count_reg + 1'b1;
                if (cursor_reg != '0)
                    cursor_next = cursor_reg + 1'b1;
                state_next = S_RD;
            end

            S_DEL:
            begin
                // move the element above the gap down one slot
                wr_en   = 1'b1;
                wr_addr = idx_reg - 1'b1;
                wr_data = rdata_reg;
                if ((CNT_W'(idx_reg) + 1'b1) < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RD;
                end
            end

            S_RD:
            begin
                rd_en      = on_el;
                rd_addr    = AW'(cursor_reg - 1'b1);
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = on_el ? rdata_ext : '0;
                    out_on_next    = on_el;
                    out_end_next   = (cursor_reg == count_reg + 1'b1);
                    out_start_next = (cursor_reg == '0);
                    out_empty_next = (count_reg == '0);
                    out_count_next = SCW'(count_reg);
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= CNT_W'(1);
            idx_reg       <= '0;
            v_reg         <= '0;
            err_reg       <= slc_pkg::ERR_OK;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_on_reg    <= 1'b0;
            out_end_reg   <= 1'b0;
            out_start_reg <= 1'b0;
            out_empty_reg <= 1'b0;
            out_count_reg <= '0;
            out_err_reg   <= slc_pkg::ERR_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            idx_reg       <= idx_next;
            v_reg         <= v_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_on_reg    <= out_on_next;
            out_end_reg   <= out_end_next;
            out_start_reg <= out_start_next;
            out_empty_reg <= out_empty_next;
            out_count_reg <= out_count_next;
            out_err_reg   <= out_err_next;
        end
    end

    // Element store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg + 1'b1)
        else $error("cursor beyond tail sentinel");

    a_one_position: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $onehot({rsp.on_element, rsp.at_end, rsp.at_start}))
        else $error("cursor position flags not exclusive");

    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");
`endif

endmodule
